// ----- design/edg_pkg.sv -----
// ----------------------------------------------------------------------------
// edg_pkg
// Types and constants shared by the echo ducking gain block.
// ----------------------------------------------------------------------------
package edg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 15;
  localparam int COUNT_W  = 18;
  localparam int CFG_W    = 18;
  localparam int INDEX_W  = 3;

  localparam logic [GAIN_W-1:0]  GAIN_MAX  = 15'd32767;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 18'd262143;

  localparam logic [GAIN_W-1:0]  THRESHOLD_RST  = 15'd65;
  localparam logic [GAIN_W-1:0]  GAIN_FLOOR_RST = 15'd327;
  localparam logic [COUNT_W-1:0] LATENCY_RST    = 18'd4800;
  localparam logic [GAIN_W-1:0]  ATTACK_RST     = 15'd682;
  localparam logic [GAIN_W-1:0]  RELEASE_RST    = 15'd6;

  typedef enum logic [INDEX_W-1:0] {
    REG_THRESHOLD       = 3'd0,
    REG_GAIN_FLOOR      = 3'd1,
    REG_LATENCY_SAMPLES = 3'd2,
    REG_ATTACK_STEP     = 3'd3,
    REG_RELEASE_STEP    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  threshold;
    logic [GAIN_W-1:0]  gain_floor;
    logic [COUNT_W-1:0] latency_samples;
    logic [GAIN_W-1:0]  attack_step;
    logic [GAIN_W-1:0]  release_step;
  } cfg_t;

endpackage

// ----- design/edg_gain_ctrl.sv -----
// ----------------------------------------------------------------------------
// edg_gain_ctrl
// Quiet counter and attack/release gain state, advanced once per request.
// ----------------------------------------------------------------------------
module edg_gain_ctrl
  import edg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [SAMPLE_W-1:0] fb_sample,
  input  cfg_t                cfg,
  output logic [GAIN_W-1:0]   gain
);

  logic [COUNT_W-1:0] quiet_count;
  logic [COUNT_W-1:0] quiet_count_next;
  logic [GAIN_W-1:0]  gain_next;
  logic [SAMPLE_W:0]  fb_ext;
  logic [SAMPLE_W:0]  mag;
  logic               loud;
  logic               releasing;
  logic [GAIN_W:0]    gain_sum;
  logic [GAIN_W-1:0]  gain_dec;

  always_comb begin
    fb_ext = {fb_sample[SAMPLE_W-1], fb_sample};
    mag    = fb_sample[SAMPLE_W-1] ? (~fb_ext + 1'b1) : fb_ext;
    loud   = mag > {2'b00, cfg.threshold};

    if (loud) begin
      quiet_count_next = '0;
    end else if (quiet_count <= cfg.latency_samples && quiet_count != COUNT_MAX) begin
      quiet_count_next = quiet_count + 1'b1;
    end else begin
      quiet_count_next = quiet_count;
    end

    releasing = quiet_count_next > cfg.latency_samples;
    gain_sum  = {1'b0, gain} + {1'b0, cfg.release_step};
    gain_dec  = (gain <= cfg.attack_step) ? '0 : gain - cfg.attack_step;

    if (releasing) begin
      gain_next = (gain_sum >= {1'b0, GAIN_MAX}) ? GAIN_MAX : gain_sum[GAIN_W-1:0];
    end else begin
      gain_next = (gain_dec < cfg.gain_floor) ? cfg.gain_floor : gain_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_count <= '0;
      gain        <= GAIN_MAX;
    end else if (step) begin
      quiet_count <= quiet_count_next;
      gain        <= gain_next;
    end
  end

endmodule

// ----- design/echo_ducking_gain.sv -----
// ----------------------------------------------------------------------------
// echo_ducking_gain
// Echo ducker: attenuates microphone samples while speaker feedback is loud.
// ----------------------------------------------------------------------------
// Each input request carries one frame: a feedback sample and the microphone
// samples. Each frame yields exactly one result request with the scaled
// samples and the gain applied to the frame. Both channels use valid/ready.
// The block is a three stage pipeline: an input register, a stage that
// updates the quiet counter and the gain, and a result register that holds
// the two Q15 products. A frame moves through them in that order, and one
// frame is accepted every cycle while the receiver does not stall.
// Each stage loads when it is empty or when the stage after it moves, so a
// result stalled by the receiver does not stop the input side until the
// whole pipeline is full. The settings are written through a plain write
// port and should only change while no frame is in flight.
// Reset empties the pipeline, clears the quiet counter, sets the gain to
// full scale and loads the default settings.
// ----------------------------------------------------------------------------
module echo_ducking_gain
  import edg_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [INDEX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] fb_sample,
  input  logic signed [SAMPLE_W-1:0] mic_0,
  input  logic signed [SAMPLE_W-1:0] mic_1,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_0,
  output logic signed [SAMPLE_W-1:0] out_1,
  output logic [GAIN_W-1:0]          gain_now
);

  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

  cfg_t cfg;

  logic                v1;
  logic                v2;
  logic                en1;
  logic                en2;
  logic                en3;
  logic [SAMPLE_W-1:0] fb_s1;
  logic [SAMPLE_W-1:0] mic0_s1;
  logic [SAMPLE_W-1:0] mic1_s1;
  logic [SAMPLE_W-1:0] mic0_s2;
  logic [SAMPLE_W-1:0] mic1_s2;
  logic [GAIN_W-1:0]   gain;
  logic signed [PROD_W-1:0] prod0;
  logic signed [PROD_W-1:0] prod1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold       <= THRESHOLD_RST;
      cfg.gain_floor      <= GAIN_FLOOR_RST;
      cfg.latency_samples <= LATENCY_RST;
      cfg.attack_step     <= ATTACK_RST;
      cfg.release_step    <= RELEASE_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_THRESHOLD:       cfg.threshold       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_FLOOR:      cfg.gain_floor      <= cfg_data[GAIN_W-1:0];
        REG_LATENCY_SAMPLES: cfg.latency_samples <= cfg_data[COUNT_W-1:0];
        REG_ATTACK_STEP:     cfg.attack_step     <= cfg_data[GAIN_W-1:0];
        REG_RELEASE_STEP:    cfg.release_step    <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      fb_s1   <= fb_sample;
      mic0_s1 <= mic_0;
      mic1_s1 <= (CHANNELS >= 2) ? mic_1 : '0;
    end
    if (en2 && v1) begin
      mic0_s2 <= mic0_s1;
      mic1_s2 <= mic1_s1;
    end
  end

  edg_gain_ctrl u_gain_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (en2 && v1),
    .fb_sample (fb_s1),
    .cfg       (cfg),
    .gain      (gain)
  );

  assign prod0 = $signed({{(PROD_W-SAMPLE_W){mic0_s2[SAMPLE_W-1]}}, mic0_s2})
               * $signed({{(PROD_W-GAIN_W){1'b0}}, gain});
  assign prod1 = $signed({{(PROD_W-SAMPLE_W){mic1_s2[SAMPLE_W-1]}}, mic1_s2})
               * $signed({{(PROD_W-GAIN_W){1'b0}}, gain});

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      out_0    <= prod0[GAIN_W+SAMPLE_W-1:GAIN_W];
      out_1    <= prod1[GAIN_W+SAMPLE_W-1:GAIN_W];
      gain_now <= gain;
    end
  end

endmodule

// ----- tb/echo_ducking_gain_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_ducking_gain_test
// Self-checking bench for the echo ducker with attack and release.
// A scoreboard object keeps its own quiet counter, gain and copy of the
// settings. For every accepted input request it computes the scaled samples
// and the gain. Each result request is checked against the oldest prediction.
// The run starts with directed frames at the reset settings. It then steps
// through extreme and random settings with random quiet and loud runs of
// feedback. Both sides stall at random, and there is one long receiver
// stall and one full pause of the sender.
// ----------------------------------------------------------------------------
module echo_ducking_gain_test;
  import edg_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int JUNK_W      = CFG_W - GAIN_W;
  localparam int N_DIRECTED  = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    sample_t            out_0;
    sample_t            out_1;
    logic [GAIN_W-1:0]  gain_now;
  } ducked_frame_t;

  localparam sample_t DIR_FB [N_DIRECTED] = '{
    0, 65, -65, 66, -66, 32767, -32768, 1, -1, 64, -32767, 0, 66, -32768, 0, 32767};
  localparam sample_t DIR_MIC0 [N_DIRECTED] = '{
    32767, -32768, 0, -1, 1, 32767, -32768, 16384, -16384, 21845, -21846, -1, 32767, 0,
    12345, -32768};
  localparam sample_t DIR_MIC1 [N_DIRECTED] = '{
    -32768, 32767, -1, 0, 32767, -32768, 1, -16385, 16383, -21845, 21846, 1, -32768, -1,
    -12345, 32767};

  class ducked_frame_board;
    cfg_t               settings;
    logic [COUNT_W-1:0] quiet_count;
    logic [GAIN_W-1:0]  gain;
    ducked_frame_t      ducked_q[$];
    int                 errors;

    function new();
      settings.threshold       = THRESHOLD_RST;
      settings.gain_floor      = GAIN_FLOOR_RST;
      settings.latency_samples = LATENCY_RST;
      settings.attack_step     = ATTACK_RST;
      settings.release_step    = RELEASE_RST;
      quiet_count = '0;
      gain        = GAIN_MAX;
      errors      = 0;
    endfunction

    function void write_reg(logic [INDEX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        REG_THRESHOLD:       settings.threshold       = data[GAIN_W-1:0];
        REG_GAIN_FLOOR:      settings.gain_floor      = data[GAIN_W-1:0];
        REG_LATENCY_SAMPLES: settings.latency_samples = data[COUNT_W-1:0];
        REG_ATTACK_STEP:     settings.attack_step     = data[GAIN_W-1:0];
        REG_RELEASE_STEP:    settings.release_step    = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // The arithmetic shift of the signed product rounds toward minus infinity.
    function sample_t scale(sample_t mic);
      logic signed [2*SAMPLE_W-1:0] product;
      product = mic * $signed({1'b0, gain});
      product = product >>> GAIN_W;
      return product[SAMPLE_W-1:0];
    endfunction

    function void note_frame(sample_t fb, sample_t mic0, sample_t mic1);
      logic [SAMPLE_W:0] magnitude;
      logic [GAIN_W:0]   raised;
      ducked_frame_t     frame;
      magnitude = fb[SAMPLE_W-1] ? -{fb[SAMPLE_W-1], fb} : {1'b0, fb};
      if (magnitude > settings.threshold) begin
        quiet_count = '0;
      end else if (quiet_count <= settings.latency_samples && quiet_count < COUNT_MAX) begin
        quiet_count = quiet_count + 1'b1;
      end
      if (quiet_count > settings.latency_samples) begin
        raised = gain + settings.release_step;
        gain = (raised >= GAIN_MAX) ? GAIN_MAX : raised[GAIN_W-1:0];
      end else begin
        gain = (gain <= settings.attack_step) ? '0 : gain - settings.attack_step;
        if (gain < settings.gain_floor) gain = settings.gain_floor;
      end
      frame.out_0    = scale(mic0);
      frame.out_1    = scale(mic1);
      frame.gain_now = gain;
      ducked_q.push_back(frame);
    endfunction

    function void check_frame(sample_t out_0, sample_t out_1, logic [GAIN_W-1:0] gain_now);
      ducked_frame_t want;
      if (ducked_q.size() == 0) begin
        $error("result request with no frame pending: out_0 %0d, out_1 %0d, gain_now %0d",
               out_0, out_1, gain_now);
        errors++;
        return;
      end
      want = ducked_q.pop_front();
      if (out_0 !== want.out_0) begin
        $error("out_0: expected %0d, got %0d", want.out_0, out_0);
        errors++;
      end
      if (out_1 !== want.out_1) begin
        $error("out_1: expected %0d, got %0d", want.out_1, out_1);
        errors++;
      end
      if (gain_now !== want.gain_now) begin
        $error("gain_now: expected %0d, got %0d", want.gain_now, gain_now);
        errors++;
      end
    endfunction

    function int pending();
      return ducked_q.size();
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  sample_t            fb_sample = '0;
  sample_t            mic_0     = '0;
  sample_t            mic_1     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sample_t            out_0;
  sample_t            out_1;
  logic [GAIN_W-1:0]  gain_now;

  ducked_frame_board board;
  bit                tx_steady;
  bit                rx_steady;
  bit                hold_outputs;
  int                idle_cycles = 0;

  echo_ducking_gain u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .fb_sample (fb_sample),
    .mic_0     (mic_0),
    .mic_1     (mic_1),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_0     (out_0),
    .out_1     (out_1),
    .gain_now  (gain_now)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("echo_ducking_gain_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_word(input logic [INDEX_W-1:0] index, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(index, data);
  endtask

  // Bits above each register's width carry random junk that must be dropped.
  task automatic apply_settings(input logic [GAIN_W-1:0] thr, input logic [GAIN_W-1:0] floor_g,
                                input logic [COUNT_W-1:0] lat,
                                input logic [GAIN_W-1:0] att, input logic [GAIN_W-1:0] rel);
    write_word(REG_THRESHOLD, {JUNK_W'($urandom), thr});
    write_word(REG_GAIN_FLOOR, {JUNK_W'($urandom), floor_g});
    write_word(REG_LATENCY_SAMPLES, CFG_W'(lat));
    write_word(REG_ATTACK_STEP, {JUNK_W'($urandom), att});
    write_word(REG_RELEASE_STEP, {JUNK_W'($urandom), rel});
    write_word(INDEX_W'(REG_RELEASE_STEP)
               + INDEX_W'($urandom_range(1, (1 << INDEX_W) - 1 - REG_RELEASE_STEP)),
               CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input sample_t fb, input sample_t m0, input sample_t m1);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    fb_sample <= fb;
    mic_0     <= m0;
    mic_1     <= m1;
    do @(posedge clk); while (!in_ready);
    board.note_frame(fb, m0, m1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic sample_t pick_fb(bit loud, int thr);
    int mag;
    if ($urandom_range(0, 7) == 0) mag = loud ? thr + 1 : thr;
    else if (loud) mag = $urandom_range(thr + 1, int'(GAIN_MAX) + 1);
    else mag = $urandom_range(0, thr);
    if (mag > int'(GAIN_MAX) || $urandom_range(0, 1)) return sample_t'(-mag);
    return sample_t'(mag);
  endfunction

  // Mostly runs of quiet or loud feedback, where a quiet run can reach release
  // only while the latency setting is short, with some single frames of unrestricted noise.
  task automatic run_phase(input int n_items, input bit pressure);
    int sent;
    int run_len;
    int roll;
    int quiet_cap;
    bit loud;
    sent = 0;
    quiet_cap = (board.settings.latency_samples > 54) ? 60
                : int'(board.settings.latency_samples) + 6;
    while (sent < n_items) begin
      roll = $urandom_range(0, 9);
      loud = roll < 5;
      if (roll < 2) run_len = 1;
      else if (loud) run_len = $urandom_range(1, 8);
      else run_len = $urandom_range(1, quiet_cap);
      repeat (run_len) begin
        if (pressure && sent == 40) hold_outputs = 1'b1;
        if (pressure && sent == 90) wait_idle();
        send_frame((roll < 2) ? sample_t'($urandom)
                              : pick_fb(loud, int'(board.settings.threshold)),
                   sample_t'($urandom), sample_t'($urandom));
        sent++;
      end
    end
    wait_idle();
  endtask

  task automatic run_receiver();
    int gap;
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      if (hold_outputs) begin
        hold_outputs = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_frame(out_0, out_1, gain_now);
    end
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    fork
      run_receiver();
    join_none
    for (int i = 0; i < N_DIRECTED; i++) send_frame(DIR_FB[i], DIR_MIC0[i], DIR_MIC1[i]);
    wait_idle();
    apply_settings('0, '0, '0, GAIN_MAX, GAIN_MAX);
    run_phase(100, 1'b0);
    apply_settings(GAIN_MAX, GAIN_MAX, COUNT_MAX, '0, '0);
    run_phase(100, 1'b0);
    for (int p = 0; p < 5; p++) begin
      apply_settings(
        GAIN_W'($urandom_range(0, 1) ? $urandom_range(0, GAIN_MAX) : $urandom_range(0, 2000)),
        GAIN_W'($urandom_range(0, 1) ? $urandom_range(0, GAIN_MAX) : $urandom_range(0, 4000)),
        COUNT_W'($urandom_range(0, 40)),
        GAIN_W'($urandom_range(0, 1) ? $urandom_range(0, GAIN_MAX) : $urandom_range(0, 3000)),
        GAIN_W'($urandom_range(0, 1) ? $urandom_range(0, GAIN_MAX) : $urandom_range(0, 3000)));
      run_phase(130, p == 1);
    end
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("echo_ducking_gain_test OK");
    end else begin
      $display("echo_ducking_gain_test NOT OK");
    end
    $finish;
  end

endmodule
